// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every rising edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/bsa_pkg.sv -----
package bsa_pkg;

    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

endpackage

// ----- hw/rtl/bsa_ram.sv -----
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bsa_find.sv -----
module bsa_find #(
    parameter int WIDTH = 64,
    parameter int IW    = $clog2(WIDTH)
) (
    input  logic [WIDTH-1:0] i_word,
    output logic             o_any,
    output logic [WIDTH-1:0] o_onehot,
    output logic [IW-1:0]    o_index
);

    logic [WIDTH-1:0] w_free;

    // Isolate the lowest free bit, then encode its position.
    assign w_free   = ~i_word;
    assign o_any    = |w_free;
    assign o_onehot = w_free & (~w_free + {{(WIDTH-1){1'b0}}, 1'b1});

    always_comb begin
        o_index = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (o_onehot[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

endmodule

// ----- hw/rtl/bitmap_slot_allocator_unit.sv -----
// Bitmap slot allocator: WORDS x WORD_BITS fixed slots, one use bit per slot,
// held in a single-port-write, registered-read RAM. An allocate looks at the
// hint word first and takes its lowest free bit; on a miss it walks the words
// from the highest index down, one word per cycle through the shared
// lowest-free-bit finder, takes the first free bit found and moves the hint to
// that word, or reports full. A free clears the bit of the given slot; an
// index past the pool or a slot not in use is reported as a bad free and
// changes nothing. Every transfer in yields exactly one transfer out, which
// carries the live slot count after that item. The block handles one item at
// a time: an allocate that hits the hint word passes the hint check, then the
// result state; one that misses adds the word scan; a free passes a divide, a
// read and a check state before the result state (a reciprocal multiply
// splits the slot index into word and bit). The next item can be taken in the
// cycle after the result is loaded. The registered RAM read sets each step.
// A finished result waits in the output register, so the next item is taken
// while it is still stalled. After reset a clearing pass zeroes the bitmap,
// one word per cycle, and no item is accepted until it ends.
module bitmap_slot_allocator_unit #(
    parameter int WORDS     = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [bsa_pkg::SLOT_W-1:0]    i_slot_to_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output bsa_pkg::t_status              o_status,
    output logic [bsa_pkg::SLOT_W-1:0]    o_slot_given,
    output logic [bsa_pkg::COUNT_W-1:0]   o_live_count
);

    import bsa_pkg::*;

    `include "assert_macros.svh"

    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int TOTAL   = WORDS * WORD_BITS;
    localparam int CW      = $clog2(TOTAL + 1);
    localparam int GW      = AW + BW;
    // idx / WORD_BITS == (idx * DIV_MUL) >> DIV_SH, exact for 10-bit idx
    localparam int DIV_SH  = 20;
    localparam int DIV_MUL = (1 << DIV_SH) / WORD_BITS + 1;
    localparam int PW      = DIV_SH + SLOT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_HINT,
        S_A_SCAN,
        S_F_DIV,
        S_F_RD,
        S_F_CHK,
        S_RESULT
    } t_state;

    t_state                r_state,      n_state;
    logic [AW-1:0]         r_clr,        n_clr;
    logic [AW-1:0]         r_hint,       n_hint;
    logic [AW-1:0]         r_scan,       n_scan;
    logic [CW-1:0]         r_count,      n_count;
    logic [SLOT_W-1:0]     r_idx,        n_idx;
    logic [SLOT_W-1:0]     r_word,       n_word;
    logic [BW-1:0]         r_bit,        n_bit;
    logic                  r_oor,        n_oor;
    t_status               r_res_status, n_res_status;
    logic [SLOT_W-1:0]     r_res_given,  n_res_given;
    logic [COUNT_W-1:0]    r_res_live,   n_res_live;
    logic                  r_out_valid,  n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [SLOT_W-1:0]     r_out_given,  n_out_given;
    logic [COUNT_W-1:0]    r_out_live,   n_out_live;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  find_any;
    logic [WORD_BITS-1:0]  find_onehot;
    logic [BW-1:0]         find_index;

    logic [AW-1:0]         w_sel;
    logic [GW-1:0]         w_slot_full;
    logic [SLOT_W-1:0]     w_slot;
    logic [PW-1:0]         w_prod;
    logic [SLOT_W-1:0]     w_rem;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_hint_hit;
    logic                  w_full_out;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One finder serves the hint check and every scan step.
    bsa_find #(
        .WIDTH (WORD_BITS),
        .IW    (BW)
    ) u_find (
        .i_word   (ram_rdata),
        .o_any    (find_any),
        .o_onehot (find_onehot),
        .o_index  (find_index)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Slot number of the bit the finder picked in the word under test.
    assign w_sel       = (r_state == S_A_HINT) ? r_hint : r_scan;
    assign w_slot_full = GW'(GW'(w_sel) * GW'(WORD_BITS)) + GW'(find_index);
    assign w_slot      = SLOT_W'(w_slot_full);

    // Word and bit of the slot being freed.
    assign w_prod = PW'(r_idx) * PW'(DIV_MUL);
    assign w_rem  = r_idx - SLOT_W'(r_word * SLOT_W'(WORD_BITS));

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_hint       = r_hint;
        n_scan       = r_scan;
        n_count      = r_count;
        n_idx        = r_idx;
        n_word       = r_word;
        n_bit        = r_bit;
        n_oor        = r_oor;
        n_res_status = r_res_status;
        n_res_given  = r_res_given;
        n_res_live   = r_res_live;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_given  = r_out_given;
        n_out_live   = r_out_live;

        ram_we    = 1'b0;
        ram_waddr = r_hint;
        ram_wdata = '0;
        ram_raddr = r_hint;

        // Drop the output once it is taken.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                // Hint word is read on every idle cycle; it is ready next cycle.
                if (w_accept) begin
                    n_idx   = i_slot_to_free;
                    n_state = (i_mode == MODE_FREE) ? S_F_DIV : S_A_HINT;
                end
            end

            S_A_HINT: begin
                if (find_any) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_hint;
                    ram_wdata    = ram_rdata | find_onehot;
                    n_count      = r_count + 1'b1;
                    n_res_status = ST_OK;
                    n_res_given  = w_slot;
                    n_res_live   = COUNT_W'(r_count + 1'b1);
                    n_state      = S_RESULT;
                end else begin
                    n_scan    = AW'(WORDS - 1);
                    ram_raddr = AW'(WORDS - 1);
                    n_state   = S_A_SCAN;
                end
            end

            S_A_SCAN: begin
                if (find_any) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_scan;
                    ram_wdata    = ram_rdata | find_onehot;
                    n_hint       = r_scan;
                    n_count      = r_count + 1'b1;
                    n_res_status = ST_OK;
                    n_res_given  = w_slot;
                    n_res_live   = COUNT_W'(r_count + 1'b1);
                    n_state      = S_RESULT;
                end else if (r_scan == '0) begin
                    n_res_status = ST_FULL;
                    n_res_given  = '0;
                    n_res_live   = COUNT_W'(r_count);
                    n_state      = S_RESULT;
                end else begin
                    // Advance to the next lower word.
                    n_scan    = r_scan - 1'b1;
                    ram_raddr = r_scan - 1'b1;
                end
            end

            S_F_DIV: begin
                n_word  = w_prod[DIV_SH +: SLOT_W];
                n_state = S_F_RD;
            end

            S_F_RD: begin
                ram_raddr = AW'(r_word);
                n_bit     = BW'(w_rem);
                n_oor     = (32'(r_idx) >= 32'(TOTAL));
                n_state   = S_F_CHK;
            end

            S_F_CHK: begin
                n_res_given = '0;
                if (r_oor || !ram_rdata[r_bit]) begin
                    n_res_status = ST_BAD_FREE;
                    n_res_live   = COUNT_W'(r_count);
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = AW'(r_word);
                    ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << r_bit);
                    n_count      = r_count - 1'b1;
                    n_res_status = ST_OK;
                    n_res_live   = COUNT_W'(r_count - 1'b1);
                end
                n_state = S_RESULT;
            end

            S_RESULT: begin
                // Hold until the output register can take the result.
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_given  = r_res_given;
                    n_out_live   = r_res_live;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_scan      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_scan      <= n_scan;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_oor        <= n_oor;
        r_res_status <= n_res_status;
        r_res_given  <= n_res_given;
        r_res_live   <= n_res_live;
        r_out_status <= n_out_status;
        r_out_given  <= n_out_given;
        r_out_live   <= n_out_live;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_given = r_out_given;
    assign o_live_count = r_out_live;

    assign w_hint_hit = (r_state == S_A_HINT) && find_any;
    assign w_full_out = o_valid && (o_status == ST_FULL);

    // A hint hit takes exactly one slot.
    `ASSERT_NEXT(a_hint_hit_count, w_hint_hit, r_count == CW'($past(r_count) + 1'b1), "hint hit count")

    // Full is reported only when every slot is live.
    `ASSERT_ALWAYS(a_full_only_when_full, !w_full_out || (o_live_count == COUNT_W'(TOTAL)), "full early")

    // No item is taken while the bitmap is being cleared.
    `ASSERT_ALWAYS(a_no_accept_in_clear, (r_state != S_CLEAR) || o_stall, "accept during clear")

    // A free never writes while the slot is out of range.
    `ASSERT_ALWAYS(a_no_write_oor, !((r_state == S_F_CHK) && r_oor && ram_we), "out-of-range write")

endmodule
